// ----- hdl/cfbr_pkg.sv -----
// ----------------------------------------------------------------------------
// cfbr_pkg
// Shared types and constants of the comb filter bank reverb.
// ----------------------------------------------------------------------------
package cfbr_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_ENABLE   = 2'd0,
    REG_FEEDBACK = 2'd1,
    REG_WET_MIX  = 2'd2
  } cfg_reg_e;

  localparam int CfgIndexBits = 2;
  localparam int GainBits     = 16;
  localparam int WetBits      = 17;
  localparam int CfgDataBits  = 17;
  localparam int FracBits     = 16;

  // Q1.16 unity and the half-LSB used for round-half-up
  localparam logic [WetBits-1:0] Unity     = 17'd65536;
  localparam logic [16:0]        RoundHalf = 17'd32768;

  localparam logic               EnableReset   = 1'b1;
  localparam logic [GainBits-1:0] FeedbackReset = 16'd32768;
  localparam logic [WetBits-1:0]  WetMixReset   = 17'd19661;

endpackage

// ----- hdl/comb_filter_bank_reverb_unit.sv -----
// ----------------------------------------------------------------------------
// comb_filter_bank_reverb_unit
// Parallel feedback comb filter reverb with dry/wet mix and bypass.
// ----------------------------------------------------------------------------
// Takes one signed sample per word and returns one mixed sample per word.
// Throughput is one word per clock while out_stall_i is low and no clearing
// pass runs; each word passes through the stage registers into the output
// register. Line k (k = 1..NUM_LINES) is a simple dual-port synchronous
// memory of k * DELAY_UNIT samples, read when the word enters and written
// back as the word leaves stage 2. After reset the block zeroes all delay
// memories, one entry per line per cycle, and holds in_stall_o high during
// that pass; configuration writes are taken at any time. With enable at 0
// the sample passes through unchanged and the delay lines hold.
module comb_filter_bank_reverb_unit
  import cfbr_pkg::*;
#(
  parameter int DELAY_UNIT  = 700,
  parameter int NUM_LINES   = 4,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [CfgIndexBits-1:0]        cfg_index_i,
  input  logic [CfgDataBits-1:0]         cfg_data_i,
  // input channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]  sample_in_i,
  // output channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]  sample_out_o
);

  localparam int SB      = SAMPLE_BITS;
  localparam int MaxLen  = NUM_LINES * DELAY_UNIT;
  localparam int CW      = $clog2(MaxLen + 1);
  localparam int SumW    = SB + $clog2(NUM_LINES) + 1;
  localparam int PW      = SB + GainBits + 1;
  localparam int FbW     = PW + 1 - FracBits;
  localparam int DryW    = SB + WetBits + 1;
  localparam int WetPW   = SumW + WetBits + 1;
  localparam int MW      = WetPW + 1;

  localparam logic signed [MW-1:0] SatMax = MW'((64'sd1 <<< (SB - 1)) - 1);
  localparam logic signed [MW-1:0] SatMin = -SatMax - MW'(1);

  function automatic logic signed [SB-1:0] sat_sample(input logic signed [MW-1:0] v);
    logic signed [SB-1:0] r;
    if (v > SatMax) begin
      r = SatMax[SB-1:0];
    end else if (v < SatMin) begin
      r = SatMin[SB-1:0];
    end else begin
      r = v[SB-1:0];
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic                enable_q;
  logic [GainBits-1:0] gain_q;
  logic [WetBits-1:0]  wet_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= EnableReset;
      gain_q   <= FeedbackReset;
      wet_q    <= WetMixReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_ENABLE:   enable_q <= cfg_data_i[0];
        REG_FEEDBACK: gain_q   <= cfg_data_i[GainBits-1:0];
        REG_WET_MIX:  wet_q    <= cfg_data_i[WetBits-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Clearing pass after reset
  // --------------------------------------------------------------------------
  logic          clr_q;
  logic [CW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      clr_cnt_q <= clr_cnt_q + CW'(1);
      if (clr_cnt_q == CW'(MaxLen - 1)) begin
        clr_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control: each stage advances when empty or when the next moves
  // --------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, out_valid_q;
  logic adv1, adv2, adv3, adv4;
  logic in_acc;

  assign adv4   = !out_valid_q || !out_stall_i;
  assign adv3   = !v3_q || adv4;
  assign adv2   = !v2_q || adv3;
  assign adv1   = !v1_q || adv2;
  assign in_acc = in_valid_i && !in_stall_o;

  assign in_stall_o  = clr_q || !adv1;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv1) v1_q        <= in_acc;
      if (adv2) v2_q        <= v1_q;
      if (adv3) v3_q        <= v2_q;
      if (adv4) out_valid_q <= v3_q;
    end
  end

  // payload registers along the pipe
  logic signed [SB-1:0] x1_q, x2_q, x3_q;
  logic                 byp1_q, byp2_q, byp3_q;

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      x1_q   <= sample_in_i;
      byp1_q <= !enable_q;
    end
    if (adv2) begin
      x2_q   <= x1_q;
      byp2_q <= byp1_q;
    end
    if (adv3) begin
      x3_q   <= x2_q;
      byp3_q <= byp2_q;
    end
  end

  // write back leaves stage 2 exactly once per reverb word
  logic line_we;
  assign line_we = v2_q && !byp2_q && adv3;

  // --------------------------------------------------------------------------
  // Delay lines: one memory per line, read on entry, written from stage 2
  // --------------------------------------------------------------------------
  logic signed [SB-1:0] rd_w [NUM_LINES];

  for (genvar k = 0; k < NUM_LINES; k++) begin : g_line
    localparam int Len = (k + 1) * DELAY_UNIT;
    localparam int AW  = $clog2(Len);

    logic signed [SB-1:0] mem [Len];
    logic signed [SB-1:0] rd_q;
    logic [AW-1:0]        pos_q;
    logic [AW-1:0]        a1_q, a2_q;
    logic signed [PW-1:0] prod2_q;
    logic [PW:0]          fb_round;
    logic signed [FbW-1:0] fb;
    logic signed [MW-1:0] wsum;

    // advance the position only for words that go through the reverb
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pos_q <= '0;
      end else if (in_acc && enable_q) begin
        pos_q <= (pos_q == AW'(Len - 1)) ? '0 : pos_q + AW'(1);
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv1) begin
        a1_q <= pos_q;
        rd_q <= mem[pos_q];
      end
      if (adv2) begin
        a2_q    <= a1_q;
        prod2_q <= PW'($signed(rd_q) * $signed({1'b0, gain_q}));
      end
    end

    assign fb_round = {prod2_q[PW-1], prod2_q} + (PW + 1)'(RoundHalf);
    assign fb       = fb_round[PW:FracBits];
    assign wsum     = MW'(x2_q) + MW'(fb);

    always_ff @(posedge clk_i) begin
      if (clr_q) begin
        if (clr_cnt_q < CW'(Len)) begin
          mem[clr_cnt_q[AW-1:0]] <= '0;
        end
      end else if (line_we) begin
        mem[a2_q] <= sat_sample(wsum);
      end
    end

    assign rd_w[k] = rd_q;
  end

  // --------------------------------------------------------------------------
  // Wet sum and mix
  // --------------------------------------------------------------------------
  logic signed [SumW-1:0]  sum1;
  logic signed [SumW-1:0]  sum2_q;
  logic [WetBits-1:0]      wet_c;
  logic [WetBits-1:0]      dry_c;
  logic signed [DryW-1:0]  pdry3_q;
  logic signed [WetPW-1:0] pwet3_q;
  logic signed [MW-1:0]    mix_total;
  logic signed [MW-FracBits-1:0] mix_y;
  logic signed [SB-1:0]    out_q;

  always_comb begin
    sum1 = '0;
    for (int i = 0; i < NUM_LINES; i++) begin
      sum1 = sum1 + SumW'(rd_w[i]);
    end
  end

  // clamp wet share at unity
  assign wet_c = (wet_q > Unity) ? Unity : wet_q;
  assign dry_c = Unity - wet_c;

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      sum2_q <= sum1;
    end
    if (adv3) begin
      pdry3_q <= DryW'($signed(x2_q) * $signed({1'b0, dry_c}));
      pwet3_q <= WetPW'($signed(sum2_q) * $signed({1'b0, wet_c}));
    end
  end

  assign mix_total = MW'(pdry3_q) + MW'(pwet3_q) + MW'(RoundHalf);
  assign mix_y     = mix_total[MW-1:FracBits];

  always_ff @(posedge clk_i) begin
    if (adv4) begin
      out_q <= byp3_q ? x3_q : sat_sample(MW'(mix_y));
    end
  end

  assign sample_out_o = out_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> in_stall_o)
    else $error("input accepted during clearing pass");

  a_no_write_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !v1_q && !v2_q && !v3_q)
    else $error("word in flight during clearing pass");

  a_stage1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !adv1) |=> (v1_q && $stable(x1_q) && $stable(byp1_q)))
    else $error("stalled stage one lost its word");

  a_out_from_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(v3_q))
    else $error("output word without a word in stage three");

endmodule
